[hdl/getb_pkg.sv]
// Package for the greedy edge tour builder: sizes, word types and the
// memory write and decision structs shared by the modules.
// No dependencies.
`default_nettype none

package getb_pkg;

	// Sizes
	localparam int MAX_CITIES = 1024;
	localparam int CITY_W     = $clog2(MAX_CITIES);
	localparam int CNT_W      = CITY_W + 1;
	localparam int DEG_W      = 2;

	localparam logic [CNT_W-1:0]  MIN_N     = CNT_W'(2);
	localparam logic [CNT_W-1:0]  MAX_N     = CNT_W'(MAX_CITIES);
	localparam logic [DEG_W-1:0]  DEG_FULL  = DEG_W'(2);
	localparam logic [CITY_W-1:0] LAST_CITY = CITY_W'(MAX_CITIES - 1);

	// Input word: one candidate edge
	typedef struct packed {
		logic [CITY_W-1:0] city_a;
		logic [CITY_W-1:0] city_b;
	} cand_t;

	// Output word: one accept result
	typedef struct packed {
		logic             accepted;
		logic             tour_closed;
		logic [CNT_W-1:0] edges_taken;
	} result_t;

	// One write into each of the three city memories
	typedef struct packed {
		logic              deg_we;
		logic [CITY_W-1:0] deg_addr;
		logic [DEG_W-1:0]  deg_data;
		logic              far_we;
		logic [CITY_W-1:0] far_addr;
		logic [CITY_W-1:0] far_data;
		logic              frag_we;
		logic [CITY_W-1:0] frag_addr;
		logic [CITY_W-1:0] frag_data;
	} mem_wr_t;

	// Registered read data for both edge endpoints
	typedef struct packed {
		logic [DEG_W-1:0]  deg_a;
		logic [DEG_W-1:0]  deg_b;
		logic [CITY_W-1:0] far_a;
		logic [CITY_W-1:0] far_b;
		logic [CITY_W-1:0] frag_a;
		logic [CITY_W-1:0] frag_b;
	} mem_rd_t;

	// Outcome of one edge: result, next counters and two write slots
	typedef struct packed {
		logic              take;
		logic              closed;
		logic [CNT_W-1:0]  count;
		logic [CITY_W-1:0] frag_ctr;
		mem_wr_t           slot1;
		mem_wr_t           slot2;
	} dec_t;

	// Limit the city count to 2..MAX_CITIES
	function automatic logic [CNT_W-1:0] clamp_n(input logic [CNT_W-1:0] v);
		logic [CNT_W-1:0] r;
		r = v;
		if (v < MIN_N) r = MIN_N;
		if (v > MAX_N) r = MAX_N;
		return r;
	endfunction

endpackage

`default_nettype wire

[hdl/getb_mem.sv]
// City state memories: degree, far end and fragment id, 1024 entries each.
// Two registered read ports and one write port per memory. Uses getb_pkg.
`default_nettype none

module getb_mem (
	input  wire logic                        clk,
	input  wire logic                        rd_en,
	input  wire logic [getb_pkg::CITY_W-1:0] rd_addr_a,
	input  wire logic [getb_pkg::CITY_W-1:0] rd_addr_b,
	input  wire getb_pkg::mem_wr_t           wr,
	output getb_pkg::mem_rd_t                rd_q
);

	logic [getb_pkg::DEG_W-1:0]  deg_mem  [getb_pkg::MAX_CITIES];
	logic [getb_pkg::CITY_W-1:0] far_mem  [getb_pkg::MAX_CITIES];
	logic [getb_pkg::CITY_W-1:0] frag_mem [getb_pkg::MAX_CITIES];

	// Write port, one entry per memory per cycle
	always_ff @(posedge clk) begin
		if (wr.deg_we) begin
			deg_mem[wr.deg_addr] <= wr.deg_data;
		end
		if (wr.far_we) begin
			far_mem[wr.far_addr] <= wr.far_data;
		end
		if (wr.frag_we) begin
			frag_mem[wr.frag_addr] <= wr.frag_data;
		end
	end

	// Read both endpoints; old data on a same-cycle write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_q.deg_a  <= deg_mem[rd_addr_a];
			rd_q.deg_b  <= deg_mem[rd_addr_b];
			rd_q.far_a  <= far_mem[rd_addr_a];
			rd_q.far_b  <= far_mem[rd_addr_b];
			rd_q.frag_a <= frag_mem[rd_addr_a];
			rd_q.frag_b <= frag_mem[rd_addr_b];
		end
	end

endmodule

`default_nettype wire

[hdl/getb_decide.sv]
// Edge decision: accept test, fragment start/extend/merge and the two
// write slots that update the city memories. Uses getb_pkg.
`default_nettype none

module getb_decide (
	input  wire getb_pkg::cand_t             cand,
	input  wire getb_pkg::mem_rd_t           rd,
	input  wire logic [getb_pkg::CNT_W-1:0]  count,
	input  wire logic [getb_pkg::CITY_W-1:0] frag_ctr,
	input  wire logic [getb_pkg::CNT_W-1:0]  n,
	output getb_pkg::dec_t                   dec
);

	logic                        in_rng;
	logic                        open_ends;
	logic                        is_new;
	logic                        ext_a;
	logic                        ext_b;
	logic                        is_merge;
	logic                        early_close;
	logic                        take;
	logic [getb_pkg::CNT_W:0]    count_inc;
	logic [getb_pkg::CNT_W-1:0]  count_nxt;
	logic [getb_pkg::CITY_W-1:0] frag_new;
	logic [getb_pkg::CITY_W-1:0] a;
	logic [getb_pkg::CITY_W-1:0] b;
	logic [getb_pkg::CITY_W-1:0] ea;
	logic [getb_pkg::CITY_W-1:0] eb;

	assign a  = cand.city_a;
	assign b  = cand.city_b;
	assign ea = rd.far_a;
	assign eb = rd.far_b;

	// Accept test
	assign in_rng    = ({1'b0, a} < n) && ({1'b0, b} < n) && (a < b);
	assign open_ends = (rd.deg_a < getb_pkg::DEG_FULL) && (rd.deg_b < getb_pkg::DEG_FULL);
	assign is_new    = (rd.deg_a == 2'd0) && (rd.deg_b == 2'd0);
	assign ext_a     = (rd.deg_a == 2'd1) && (rd.deg_b == 2'd0);
	assign ext_b     = (rd.deg_a == 2'd0) && (rd.deg_b == 2'd1);
	assign is_merge  = !is_new && !ext_a && !ext_b;

	// Same fragment closes a cycle: only allowed as the last edge
	assign count_inc   = {1'b0, count} + (getb_pkg::CNT_W+1)'(1);
	assign early_close = (rd.frag_a == rd.frag_b) && (count_inc < {1'b0, n});
	assign take        = in_rng && open_ends && !(is_merge && early_close);

	assign count_nxt = take ? count_inc[getb_pkg::CNT_W-1:0] : count;
	assign frag_new  = frag_ctr + getb_pkg::CITY_W'(1);

	// Result, counters and write slots; slot2 follows slot1 so a later write wins
	always_comb begin
		dec = '0;

		dec.take     = take;
		dec.count    = count_nxt;
		dec.closed   = take && (count_nxt == n);
		dec.frag_ctr = (take && is_new) ? frag_new : frag_ctr;

		dec.slot1.deg_we   = take;
		dec.slot1.deg_addr = a;
		dec.slot1.deg_data = rd.deg_a + 2'd1;
		dec.slot2.deg_we   = take;
		dec.slot2.deg_addr = b;
		dec.slot2.deg_data = rd.deg_b + 2'd1;

		dec.slot1.far_we  = take;
		dec.slot2.far_we  = take;
		dec.slot1.frag_we = take;

		if (is_new) begin
			dec.slot1.far_addr  = a;
			dec.slot1.far_data  = b;
			dec.slot2.far_addr  = b;
			dec.slot2.far_data  = a;
			dec.slot1.frag_addr = a;
			dec.slot1.frag_data = frag_new;
			dec.slot2.frag_we   = take;
			dec.slot2.frag_addr = b;
			dec.slot2.frag_data = frag_new;
		end else if (ext_a) begin
			dec.slot1.far_addr  = b;
			dec.slot1.far_data  = ea;
			dec.slot2.far_addr  = ea;
			dec.slot2.far_data  = b;
			dec.slot1.frag_addr = b;
			dec.slot1.frag_data = rd.frag_a;
		end else if (ext_b) begin
			dec.slot1.far_addr  = a;
			dec.slot1.far_data  = eb;
			dec.slot2.far_addr  = eb;
			dec.slot2.far_data  = a;
			dec.slot1.frag_addr = a;
			dec.slot1.frag_data = rd.frag_b;
		end else begin
			dec.slot1.far_addr  = ea;
			dec.slot1.far_data  = eb;
			dec.slot2.far_addr  = eb;
			dec.slot2.far_data  = ea;
			dec.slot1.frag_addr = ea;
			dec.slot1.frag_data = rd.frag_b;
		end
	end

endmodule

`default_nettype wire

[hdl/getb_outq.sv]
// Two-entry result queue between the decision stage and the output port.
// Uses getb_pkg.
`default_nettype none

module getb_outq (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire getb_pkg::result_t push_data,
	output logic                   full,
	output logic                   res_valid,
	input  wire logic              res_ready,
	output getb_pkg::result_t      res
);

	getb_pkg::result_t slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        cnt_q;
	logic              pop;

	assign res_valid = (cnt_q != 2'd0);
	assign full      = (cnt_q == 2'd2);
	assign res       = slot_q[rd_ptr_q];
	assign pop       = res_valid && res_ready;

	// Storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

`default_nettype wire

[hdl/greedy_edge_tour_builder_top.sv]
// Greedy edge tour builder, top level. Uses getb_pkg, getb_mem, getb_decide, getb_outq.
// A result word is offered once its edge word has passed the read stage (v_s1)
// and been pushed into the result queue. The next edge word is taken only after
// the read and both write slots on the single write port of each memory; a full
// result queue also holds it off. Reset and each city_count write start a pass
// that zeroes the degree memory; no edge word is accepted during it.
`default_nettype none

module greedy_edge_tour_builder_top (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cfg_we,
	input  wire logic [getb_pkg::CNT_W-1:0] cfg_wdata,
	input  wire logic                       cand_valid,
	output logic                            cand_ready,
	input  wire getb_pkg::cand_t            cand,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output getb_pkg::result_t               res
);

	logic                        accept;
	logic                        clear_q;
	logic [getb_pkg::CITY_W-1:0] clr_addr_q;
	logic [getb_pkg::CNT_W-1:0]  n_q;
	logic [getb_pkg::CNT_W-1:0]  count_q;
	logic [getb_pkg::CITY_W-1:0] frag_ctr_q;
	logic                        v_s1;
	logic                        v_s2;
	getb_pkg::cand_t             cand_s1;
	getb_pkg::mem_wr_t           slot2_s2;
	getb_pkg::mem_wr_t           wr;
	getb_pkg::mem_rd_t           rd_q;
	getb_pkg::dec_t              dec;
	getb_pkg::result_t           res_new;
	logic                        q_full;

	// Interlock: next word only once both write slots are done, no clear pass runs and the result queue is not full
	assign cand_ready = !clear_q && !v_s1 && !v_s2 && !q_full;
	assign accept     = cand_valid && cand_ready;

	// Memory write port select: clear pass, then slot 1, then slot 2
	always_comb begin
		wr = '0;
		if (clear_q) begin
			wr.deg_we   = 1'b1;
			wr.deg_addr = clr_addr_q;
			wr.deg_data = '0;
		end else if (v_s1) begin
			wr = dec.slot1;
		end else if (v_s2) begin
			wr = slot2_s2;
		end
	end

	getb_mem u_mem (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr_a (cand.city_a),
		.rd_addr_b (cand.city_b),
		.wr        (wr),
		.rd_q      (rd_q)
	);

	getb_decide u_decide (
		.cand     (cand_s1),
		.rd       (rd_q),
		.count    (count_q),
		.frag_ctr (frag_ctr_q),
		.n        (n_q),
		.dec      (dec)
	);

	assign res_new.accepted    = dec.take;
	assign res_new.tour_closed = dec.closed;
	assign res_new.edges_taken = dec.count;

	getb_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (v_s1),
		.push_data (res_new),
		.full      (q_full),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Edge payload and second write slot
	always_ff @(posedge clk) begin
		if (accept) begin
			cand_s1 <= cand;
		end
		if (v_s1) begin
			slot2_s2 <= dec.slot2;
		end
	end

	// Control: stage valids, counters, city count and clear pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			clear_q    <= 1'b1;
			clr_addr_q <= '0;
			n_q        <= getb_pkg::MIN_N;
			count_q    <= '0;
			frag_ctr_q <= '0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			if (cfg_we) begin
				n_q        <= getb_pkg::clamp_n(cfg_wdata);
				count_q    <= '0;
				frag_ctr_q <= '0;
				clear_q    <= 1'b1;
				clr_addr_q <= '0;
			end else begin
				if (v_s1) begin
					count_q    <= dec.count;
					frag_ctr_q <= dec.frag_ctr;
				end
				if (clear_q) begin
					clr_addr_q <= clr_addr_q + getb_pkg::CITY_W'(1);
					if (clr_addr_q == getb_pkg::LAST_CITY) begin
						clear_q <= 1'b0;
					end
				end
			end
		end
	end

	// Checks
	a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clear_q |-> !cand_ready)
		else $error("edge word accepted during degree clear");

	a_slot_spacing: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !cand_ready ##1 !cand_ready)
		else $error("edge word accepted before both write slots finished");

	a_degree_legal: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (rd_q.deg_a != 2'd3) && (rd_q.deg_b != 2'd3))
		else $error("degree memory holds an impossible value");

	a_closed_taken: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && dec.closed |-> dec.take && (dec.count == n_q))
		else $error("tour closed without taking the closing edge");

endmodule

`default_nettype wire
